[design/ihp_pkg.sv]
// shared types and constants for the ipv4 header parser
`default_nettype none
package ihp_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_VERSION  = 3'd1;
	localparam logic [2:0] ST_TRUNC    = 3'd2;
	localparam logic [2:0] ST_OPTLEN   = 3'd3;
	localparam logic [2:0] ST_SHORTHDR = 3'd4;

	localparam logic [1:0] PH_TYPE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_PAD  = 2'd3;

	localparam logic [3:0] IP_VERSION   = 4'd4;
	localparam logic [3:0] MIN_WORDS    = 4'd5;
	localparam logic [7:0] OPT_END      = 8'd0;
	localparam logic [7:0] OPT_NOP      = 8'd1;
	localparam logic [7:0] OPT_MIN_LEN  = 8'd2;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  header_words;
		logic [5:0]  dscp;
		logic [15:0] content_length;
		logic [15:0] packet_id;
		logic [15:0] flags_and_fragment;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol_number;
		logic [15:0] header_checksum;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [5:0]  option_bytes;
	} result_t;

endpackage
`default_nettype wire

[design/ipv4_header_parser_core.sv]
// top level of the streaming ipv4 header parser
//
//  channel  | handshake            | beat payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | data_byte, frame_end
//  output   | out_valid / out_ready| status and the eleven header result fields
//
// one byte per cycle sustained while the output is not stalled: a byte
// is held in the input register, then is parsed into the result register,
// so out_valid rises when the result register loads the beat that causes it
// exactly one result per frame: last header byte, first error or truncation
// reset clears the frame position, option walker and both valid flags
// a stalled output holds the byte in the input register and drops in_ready
`default_nettype none
module ipv4_header_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [3:0]       header_words,
	output logic [5:0]       dscp,
	output logic [15:0]      content_length,
	output logic [15:0]      packet_id,
	output logic [15:0]      flags_and_fragment,
	output logic [7:0]       time_to_live,
	output logic [7:0]       protocol_number,
	output logic [15:0]      header_checksum,
	output logic [31:0]      source_address,
	output logic [31:0]      destination_address,
	output logic [5:0]       option_bytes
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             end_s1;
	logic             advance;
	logic             can_take;
	logic             res_valid;
	ihp_pkg::result_t res;
	ihp_pkg::result_t res_q;

	assign advance = valid_s1 && can_take;

	ihp_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.end_s1    (end_s1)
	);

	ihp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.byte_s1   (byte_s1),
		.end_s1    (end_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ihp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign status              = res_q.status;
	assign header_words        = res_q.header_words;
	assign dscp                = res_q.dscp;
	assign content_length      = res_q.content_length;
	assign packet_id           = res_q.packet_id;
	assign flags_and_fragment  = res_q.flags_and_fragment;
	assign time_to_live        = res_q.time_to_live;
	assign protocol_number     = res_q.protocol_number;
	assign header_checksum     = res_q.header_checksum;
	assign source_address      = res_q.source_address;
	assign destination_address = res_q.destination_address;
	assign option_bytes        = res_q.option_bytes;

endmodule
`default_nettype wire

[design/ihp_in_stage.sv]
// input register for incoming frame bytes
`default_nettype none
module ihp_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1,
	output logic            end_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

endmodule
`default_nettype wire

[design/ihp_parse.sv]
// header field capture, option walk and result decision for one byte
`default_nettype none
module ihp_parse (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] byte_s1,
	input  wire logic       end_s1,
	output logic            res_valid,
	output ihp_pkg::result_t res
);

	logic [5:0]  pos_q, pos_d;
	logic [3:0]  words_q, words_d;
	logic [5:0]  dscp_q, dscp_d;
	logic [15:0] tlen_q, tlen_d;
	logic [15:0] id_q, id_d;
	logic [15:0] frag_q, frag_d;
	logic [7:0]  ttl_q, ttl_d;
	logic [7:0]  proto_q, proto_d;
	logic [15:0] csum_q, csum_d;
	logic [31:0] src_q, src_d;
	logic [31:0] dst_q, dst_d;
	logic [1:0]  phase_q, phase_d;
	logic [7:0]  skip_q, skip_d;
	logic [5:0]  cnt_q, cnt_d;
	logic        reported_q;

	logic [5:0]  hdr_bytes;
	logic [5:0]  room;
	logic [7:0]  opt_len;
	logic        done;
	logic [2:0]  done_status;

	assign hdr_bytes = {words_q, 2'b00};
	assign room      = hdr_bytes - pos_q - 6'd1;
	assign opt_len   = byte_s1 - ihp_pkg::OPT_MIN_LEN;

	always_comb begin
		pos_d       = pos_q;
		words_d     = words_q;
		dscp_d      = dscp_q;
		tlen_d      = tlen_q;
		id_d        = id_q;
		frag_d      = frag_q;
		ttl_d       = ttl_q;
		proto_d     = proto_q;
		csum_d      = csum_q;
		src_d       = src_q;
		dst_d       = dst_q;
		phase_d     = phase_q;
		skip_d      = skip_q;
		cnt_d       = cnt_q;
		done        = 1'b0;
		done_status = ihp_pkg::ST_OK;

		unique case (pos_q) inside
			6'd0: begin
				if (byte_s1[7:4] != ihp_pkg::IP_VERSION) begin
					done        = 1'b1;
					done_status = ihp_pkg::ST_VERSION;
				end else begin
					words_d = byte_s1[3:0];
					if (byte_s1[3:0] < ihp_pkg::MIN_WORDS) begin
						done        = 1'b1;
						done_status = ihp_pkg::ST_SHORTHDR;
					end
				end
			end
			6'd1: dscp_d = byte_s1[7:2];
			6'd2, 6'd3: tlen_d = {tlen_q[7:0], byte_s1};
			6'd4, 6'd5: id_d = {id_q[7:0], byte_s1};
			6'd6, 6'd7: frag_d = {frag_q[7:0], byte_s1};
			6'd8: ttl_d = byte_s1;
			6'd9: proto_d = byte_s1;
			6'd10, 6'd11: csum_d = {csum_q[7:0], byte_s1};
			[6'd12:6'd15]: src_d = {src_q[23:0], byte_s1};
			[6'd16:6'd19]: dst_d = {dst_q[23:0], byte_s1};
			default: begin
				unique case (phase_q)
					ihp_pkg::PH_TYPE: begin
						if (byte_s1 == ihp_pkg::OPT_END) begin
							phase_d = ihp_pkg::PH_PAD;
						end else if (byte_s1 == ihp_pkg::OPT_NOP) begin
							cnt_d = cnt_q + 6'd1;
						end else begin
							cnt_d   = cnt_q + 6'd1;
							phase_d = ihp_pkg::PH_LEN;
						end
					end
					ihp_pkg::PH_LEN: begin
						if (byte_s1 < ihp_pkg::OPT_MIN_LEN || opt_len > {2'b00, room}) begin
							done        = 1'b1;
							done_status = ihp_pkg::ST_OPTLEN;
						end else begin
							cnt_d   = cnt_q + 6'd1;
							skip_d  = opt_len;
							phase_d = (opt_len == 8'd0) ? ihp_pkg::PH_TYPE : ihp_pkg::PH_DATA;
						end
					end
					ihp_pkg::PH_DATA: begin
						cnt_d  = cnt_q + 6'd1;
						skip_d = skip_q - 8'd1;
						if (skip_q == 8'd1) begin
							phase_d = ihp_pkg::PH_TYPE;
						end
					end
					default: begin
					end
				endcase
			end
		endcase

		if (!done && pos_q != 6'd0 && ({1'b0, pos_q} + 7'd1 == {1'b0, hdr_bytes})) begin
			done        = 1'b1;
			done_status = (phase_d == ihp_pkg::PH_LEN) ? ihp_pkg::ST_OPTLEN : ihp_pkg::ST_OK;
		end
		if (!done) begin
			pos_d = pos_q + 6'd1;
		end
	end

	always_comb begin
		res       = '0;
		res_valid = !reported_q && (done || end_s1);
		res.status = done ? done_status : ihp_pkg::ST_TRUNC;
		if (done && done_status == ihp_pkg::ST_OK) begin
			res.header_words        = words_d;
			res.dscp                = dscp_d;
			res.content_length      = tlen_d - {10'd0, words_d, 2'b00};
			res.packet_id           = id_d;
			res.flags_and_fragment  = frag_d;
			res.time_to_live        = ttl_d;
			res.protocol_number     = proto_d;
			res.header_checksum     = csum_d;
			res.source_address      = src_d;
			res.destination_address = dst_d;
			res.option_bytes        = cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= ihp_pkg::PH_TYPE;
			skip_q     <= '0;
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else if (fire) begin
			if (end_s1) begin
				pos_q      <= '0;
				phase_q    <= ihp_pkg::PH_TYPE;
				skip_q     <= '0;
				cnt_q      <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				pos_q      <= pos_d;
				phase_q    <= phase_d;
				skip_q     <= skip_d;
				cnt_q      <= cnt_d;
				reported_q <= done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
		end else if (fire && !reported_q) begin
			words_q <= words_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !reported_q) begin
			dscp_q  <= dscp_d;
			tlen_q  <= tlen_d;
			id_q    <= id_d;
			frag_q  <= frag_d;
			ttl_q   <= ttl_d;
			proto_q <= proto_d;
			csum_q  <= csum_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
		end
	end

endmodule
`default_nettype wire

[design/ihp_out_stage.sv]
// result register toward the downstream side
`default_nettype none
module ihp_out_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire ihp_pkg::result_t res,
	output logic             can_take,
	output logic             out_valid,
	input  wire logic        out_ready,
	output ihp_pkg::result_t res_q
);

	assign can_take = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_take) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_take) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

[design/ihp_checker.sv]
// port-level checks for the ipv4 header parser, bound to the top level
`default_nettype none
module ihp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [3:0]  header_words,
	input wire logic [5:0]  option_bytes,
	input wire logic [31:0] source_address
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result beat changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ihp_pkg::ST_OK |->
			header_words == 4'd0 && option_bytes == 6'd0 && source_address == 32'd0)
		else $error("error result carries field data");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ihp_pkg::ST_OK |->
			header_words >= ihp_pkg::MIN_WORDS && option_bytes <= 6'd40)
		else $error("ok result with impossible header length or option count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ihp_pkg::ST_SHORTHDR)
		else $error("undefined status code");

endmodule

bind ipv4_header_parser_core ihp_checker u_ihp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.header_words   (header_words),
	.option_bytes   (option_bytes),
	.source_address (source_address)
);
`default_nettype wire
